### design/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg
// types, codes and constants shared by the order book matcher modules
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int DefaultSlots = 32;

  typedef enum logic [1:0] {
    FUNC_LIMIT  = 2'd0,
    FUNC_MARKET = 2'd1,
    FUNC_CANCEL = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]  func;
    logic        side;
    logic [63:0] order_ref;
    logic [31:0] price;
    logic [31:0] quantity;
  } order_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] maker_id;
    logic [31:0] fill_price;
    logic [31:0] fill_qty;
    logic [31:0] remaining_qty;
    logic        rested;
    logic        book_full;
    logic        cancel_found;
    logic [63:0] trade_total;
    logic [63:0] volume_total;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_STATUS
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic do_fill;
    logic do_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic match_found;
    logic fill_more;
    logic single;
  } stat_t;

endpackage

### design/lobm_ctrl.sv
// ----------------------------------------------------------------------------
// lobm_ctrl
// sequencer: scan slots, emit fills, emit the final status
// ----------------------------------------------------------------------------
module lobm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic            out_busy,
  input  lobm_pkg::stat_t stat,
  output lobm_pkg::cmd_t  cmd,
  output logic            idle
);
  import lobm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = stat.single ? ST_STATUS : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_last) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (!out_busy) begin
          if (!stat.match_found) state_next = ST_STATUS;
          else if (stat.fill_more) state_next = ST_SCAN;
          else state_next = ST_STATUS;
        end
      end
      ST_STATUS: begin
        if (!out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    idle = 1'b0;
    case (state)
      ST_IDLE: begin
        idle = 1'b1;
        cmd.load = in_fire;
        cmd.scan_start = in_fire;
      end
      ST_SCAN: cmd.scan_step = 1'b1;
      ST_FILL: begin
        cmd.do_fill = !out_busy && stat.match_found;
        cmd.scan_start = !out_busy;
      end
      ST_STATUS: cmd.do_status = !out_busy;
      default: cmd = '0;
    endcase
  end
endmodule

### design/lobm_datapath.sv
// ----------------------------------------------------------------------------
// lobm_datapath
// slot table, best-entry scan, fill arithmetic, counters and output register
// ----------------------------------------------------------------------------
module lobm_datapath #(
  parameter int ORDER_SLOTS = lobm_pkg::DefaultSlots
) (
  input  logic              clk,
  input  logic              rst,
  input  lobm_pkg::order_t  ord,
  input  lobm_pkg::cmd_t    cmd,
  input  logic              out_take,
  output lobm_pkg::stat_t   stat,
  output logic              out_busy,
  output logic              res_valid,
  output lobm_pkg::result_t res
);
  import lobm_pkg::*;

  localparam int IW = $clog2(ORDER_SLOTS);

  logic [ORDER_SLOTS-1:0] slot_valid;
  logic                   slot_side  [ORDER_SLOTS];
  logic [31:0]            slot_price [ORDER_SLOTS];
  logic [31:0]            slot_qty   [ORDER_SLOTS];
  logic [63:0]            slot_id    [ORDER_SLOTS];
  logic [31:0]            slot_stamp [ORDER_SLOTS];
  logic [31:0]            arrival;
  logic [63:0]            trades;
  logic [63:0]            volume;

  logic [1:0]  func;
  logic        side;
  logic [63:0] oid;
  logic [31:0] limit;
  logic [31:0] rem;

  logic [IW-1:0] idx;
  logic          best_ok;
  logic [IW-1:0] best;
  logic [31:0]   best_px;
  logic [31:0]   best_age;

  // scan candidate
  logic        cand_ok, cand_better;
  logic [31:0] cp, cage;
  logic [31:0] fill;
  logic [31:0] rem_after;
  logic        cancel_hit;
  logic [IW-1:0] cancel_idx;
  logic        free_ok;
  logic [IW-1:0] free_idx;

  assign cp   = slot_price[idx];
  assign cage = arrival - slot_stamp[idx];

  always_comb begin
    cand_ok = slot_valid[idx] && (slot_side[idx] != side);
    if (func == FUNC_LIMIT) begin
      if (!side && cp > limit) cand_ok = 1'b0;
      if (side && cp < limit) cand_ok = 1'b0;
    end
    if (!best_ok) cand_better = 1'b1;
    else if (cp == best_px) cand_better = cage > best_age;
    else if (!side) cand_better = cp < best_px;
    else cand_better = cp > best_px;
  end

  assign fill      = (rem < slot_qty[best]) ? rem : slot_qty[best];
  assign rem_after = rem - fill;

  always_comb begin
    cancel_hit = 1'b0;
    cancel_idx = '0;
    free_ok = 1'b0;
    free_idx = '0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_id[i] == oid) begin
        cancel_hit = 1'b1;
        cancel_idx = IW'(i);
      end
      if (!slot_valid[i]) begin
        free_ok = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign out_busy = res_valid && !out_take;

  assign stat.scan_last   = (idx == IW'(ORDER_SLOTS - 1));
  assign stat.match_found = best_ok && (rem != 32'd0);
  assign stat.fill_more   = (rem_after != 32'd0);
  assign stat.single      = (ord.func == FUNC_CANCEL) || (ord.func == FUNC_NONE)
                            || (ord.quantity == 32'd0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func  <= ord.func;
      side  <= ord.side;
      oid   <= ord.order_ref;
      limit <= ord.price;
      rem   <= ord.quantity;
    end
    if (cmd.scan_start) begin
      idx <= '0;
    end else if (cmd.scan_step && !stat.scan_last) begin
      idx <= idx + IW'(1);
    end
    if (cmd.scan_step && cand_ok && cand_better) begin
      best <= idx;
      best_px <= cp;
      best_age <= cage;
    end
    if (cmd.do_fill) begin
      rem <= rem_after;
      slot_qty[best] <= slot_qty[best] - fill;
      res.kind          <= 1'b0;
      res.maker_id      <= slot_id[best];
      res.fill_price    <= slot_price[best];
      res.fill_qty      <= fill;
      res.remaining_qty <= rem_after;
      res.rested        <= 1'b0;
      res.book_full     <= 1'b0;
      res.cancel_found  <= 1'b0;
      res.trade_total   <= trades + 64'd1;
      res.volume_total  <= volume + {32'd0, fill};
      res.last          <= 1'b0;
    end
    if (cmd.do_status) begin
      res.kind          <= 1'b1;
      res.maker_id      <= '0;
      res.fill_price    <= '0;
      res.fill_qty      <= '0;
      res.remaining_qty <= (func == FUNC_LIMIT || func == FUNC_MARKET) ? rem : 32'd0;
      res.rested        <= (func == FUNC_LIMIT) && rem != 32'd0 && free_ok;
      res.book_full     <= (func == FUNC_LIMIT) && rem != 32'd0 && !free_ok;
      res.cancel_found  <= (func == FUNC_CANCEL) && cancel_hit;
      res.trade_total   <= trades;
      res.volume_total  <= volume;
      res.last          <= 1'b1;
      if (func == FUNC_LIMIT && rem != 32'd0 && free_ok) begin
        slot_side[free_idx]  <= side;
        slot_price[free_idx] <= limit;
        slot_qty[free_idx]   <= rem;
        slot_id[free_idx]    <= oid;
        slot_stamp[free_idx] <= arrival;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      arrival    <= '0;
      trades     <= '0;
      volume     <= '0;
      best_ok    <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (cmd.do_fill || cmd.do_status) res_valid <= 1'b1;
      else if (out_take) res_valid <= 1'b0;
      if (cmd.scan_start) begin
        best_ok <= 1'b0;
      end else if (cmd.scan_step && cand_ok) begin
        best_ok <= 1'b1;
      end
      if (cmd.do_fill) begin
        trades <= trades + 64'd1;
        volume <= volume + {32'd0, fill};
        if (fill == slot_qty[best]) slot_valid[best] <= 1'b0;
      end
      if (cmd.do_status) begin
        if (func == FUNC_CANCEL && cancel_hit) slot_valid[cancel_idx] <= 1'b0;
        if (func == FUNC_LIMIT && rem != 32'd0 && free_ok) begin
          slot_valid[free_idx] <= 1'b1;
          arrival <= arrival + 32'd1;
        end
      end
    end
  end
endmodule

### design/limit_order_book_matcher.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// price-time priority limit order book with a bounded slot table
// ----------------------------------------------------------------------------
// orders arrive on in_valid/in_ready as one order_t request; results leave on
// out_valid/out_ready as result_t requests, zero or more fills then one
// status with last set.
// an order is accepted while the sequencer is idle. a limit or market order then
// runs scans: a best-entry search that steps through every slot in turn,
// then a fill state that applies the fill.
// every fill needs a scan, and an order left with quantity after its fills
// ends with one more scan that finds nothing.
// the status follows; a cancel, a zero quantity order or an unused code goes
// straight from the accept to status.
// a new order is taken only once the previous status has been issued.
// results sit in one output register; when the receiver stalls the
// sequencer holds until the register is free, with no loss.
// reset empties the book and clears the arrival, trade and volume counters;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module limit_order_book_matcher #(
  parameter int ORDER_SLOTS = lobm_pkg::DefaultSlots
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lobm_pkg::order_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lobm_pkg::result_t out_data
);
  import lobm_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  busy;
  logic  idle;

  assign in_ready = idle;

  lobm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_valid && idle),
    .out_busy (busy),
    .stat     (stat),
    .cmd      (cmd),
    .idle     (idle)
  );

  lobm_datapath #(.ORDER_SLOTS(ORDER_SLOTS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ord       (in_data),
    .cmd       (cmd),
    .out_take  (out_ready),
    .stat      (stat),
    .out_busy  (busy),
    .res_valid (out_valid),
    .res       (out_data)
  );
endmodule

### tb/sv/tb_limit_order_book_matcher.sv
// ----------------------------------------------------------------------------
// tb_limit_order_book_matcher
// drives limit, market and cancel orders through the matcher, predicts fills
// and status records from an internal model of the book and checks each
// result field by field, with random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_limit_order_book_matcher;
  import lobm_pkg::*;

  localparam int Slots = 32;
  localparam int WatchdogLimit = 20000;
  localparam int PendDepth = 512;
  localparam int ExpDepth = 8192;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_ready;
  order_t  in_data = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  result_t out_data;

  always #5 clk = ~clk;

  limit_order_book_matcher #(.ORDER_SLOTS(Slots)) u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  // book model
  logic        bk_valid[Slots];
  logic        bk_side[Slots];
  logic [31:0] bk_price[Slots];
  logic [31:0] bk_qty[Slots];
  logic [63:0] bk_id[Slots];
  logic [31:0] bk_stamp[Slots];
  logic [31:0] arrivals;
  logic [63:0] trades;
  logic [63:0] volume;

  order_t  pend_buf[PendDepth];
  int      pend_head = 0;
  int      pend_tail = 0;
  result_t exp_buf[ExpDepth];
  int      exp_head = 0;
  int      exp_tail = 0;
  int      errors = 0;
  int      accepted = 0;
  int      hold_off = 0;
  bit      pause_sender = 0;
  logic [63:0] id_seq = 64'd1;
  logic [63:0] live_ids[PendDepth];
  int      live_count = 0;

  function automatic result_t make_result(logic kind, logic [63:0] maker,
      logic [31:0] px, logic [31:0] q, logic [31:0] rem, logic rested,
      logic full, logic found);
    result_t r;
    r.kind = kind; r.maker_id = maker; r.fill_price = px; r.fill_qty = q;
    r.remaining_qty = rem; r.rested = rested; r.book_full = full;
    r.cancel_found = found; r.trade_total = trades; r.volume_total = volume;
    r.last = kind;
    return r;
  endfunction

  task automatic add_expected(result_t r);
    exp_buf[exp_tail] = r;
    exp_tail++;
  endtask

  function automatic int best_opposite(logic side, logic is_limit, logic [31:0] lim);
    int best;
    logic [31:0] best_age, age, p;
    logic better;
    best = -1;
    best_age = '0;
    for (int i = 0; i < Slots; i++) begin
      if (!bk_valid[i] || bk_side[i] == side) continue;
      p = bk_price[i];
      if (is_limit && side == 1'b0 && p > lim) continue;
      if (is_limit && side == 1'b1 && p < lim) continue;
      age = arrivals - bk_stamp[i];
      if (best < 0) better = 1'b1;
      else if (p == bk_price[best]) better = age > best_age;
      else if (side == 1'b0) better = p < bk_price[best];
      else better = p > bk_price[best];
      if (better) begin
        best = i;
        best_age = age;
      end
    end
    return best;
  endfunction

  task automatic predict_order(order_t o);
    logic [31:0] rem, fill;
    logic found, rested, full;
    int b, free_slot;
    rem = o.quantity;
    found = 1'b0;
    rested = 1'b0;
    full = 1'b0;
    free_slot = -1;
    if (o.func == FUNC_CANCEL) begin
      for (int i = 0; i < Slots; i++) begin
        if (bk_valid[i] && bk_id[i] == o.order_ref) begin
          bk_valid[i] = 1'b0;
          found = 1'b1;
          break;
        end
      end
      add_expected(make_result(1'b1, '0, '0, '0, '0, 0, 0, found));
    end else if (o.func == FUNC_NONE) begin
      add_expected(make_result(1'b1, '0, '0, '0, '0, 0, 0, 0));
    end else begin
      while (rem > 0) begin
        b = best_opposite(o.side, o.func == FUNC_LIMIT, o.price);
        if (b < 0) break;
        fill = (rem < bk_qty[b]) ? rem : bk_qty[b];
        rem -= fill;
        bk_qty[b] -= fill;
        trades += 64'd1;
        volume += 64'(fill);
        add_expected(make_result(1'b0, bk_id[b], bk_price[b], fill, rem, 0, 0, 0));
        if (bk_qty[b] == 0) bk_valid[b] = 1'b0;
      end
      if (o.func == FUNC_LIMIT && rem > 0) begin
        for (int i = 0; i < Slots; i++) begin
          if (!bk_valid[i]) begin
            free_slot = i;
            break;
          end
        end
        if (free_slot >= 0) begin
          bk_valid[free_slot] = 1'b1;
          bk_side[free_slot] = o.side;
          bk_price[free_slot] = o.price;
          bk_qty[free_slot] = rem;
          bk_id[free_slot] = o.order_ref;
          bk_stamp[free_slot] = arrivals;
          arrivals += 32'd1;
          rested = 1'b1;
        end else begin
          full = 1'b1;
        end
      end
      add_expected(make_result(1'b1, '0, '0, '0, rem, rested, full, 0));
    end
  endtask

  function automatic order_t new_order(func_t f, logic side, logic [31:0] px,
      logic [31:0] q);
    order_t o;
    o.func = f; o.side = side; o.price = px; o.quantity = q;
    o.order_ref = id_seq;
    id_seq += 64'd1;
    return o;
  endfunction

  task automatic queue_order(order_t o);
    pend_buf[pend_tail] = o;
    pend_tail++;
    if (o.func == FUNC_LIMIT) begin
      live_ids[live_count] = o.order_ref;
      live_count++;
    end
  endtask

  // driver: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_order(in_data);
        accepted <= accepted + 1;
      end
      if (in_valid && !in_ready) begin
        // hold the request
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pend_head < pend_tail && !pause_sender) begin
        in_data <= pend_buf[pend_head];
        pend_head++;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(12, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern and monitor
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (exp_head == exp_tail) begin
          $error("unexpected result kind=%0d", out_data.kind);
          errors++;
        end else begin
          result_t e;
          e = exp_buf[exp_head];
          exp_head++;
          if (e.kind != out_data.kind) begin
            $error("kind exp %0h got %0h", e.kind, out_data.kind); errors++; end
          if (e.maker_id != out_data.maker_id) begin
            $error("maker_id exp %0h got %0h", e.maker_id, out_data.maker_id);
            errors++; end
          if (e.fill_price != out_data.fill_price) begin
            $error("fill_price exp %0h got %0h", e.fill_price, out_data.fill_price);
            errors++; end
          if (e.fill_qty != out_data.fill_qty) begin
            $error("fill_qty exp %0h got %0h", e.fill_qty, out_data.fill_qty);
            errors++; end
          if (e.remaining_qty != out_data.remaining_qty) begin
            $error("remaining_qty exp %0h got %0h", e.remaining_qty,
                   out_data.remaining_qty); errors++; end
          if (e.rested != out_data.rested) begin
            $error("rested exp %0h got %0h", e.rested, out_data.rested); errors++; end
          if (e.book_full != out_data.book_full) begin
            $error("book_full exp %0h got %0h", e.book_full, out_data.book_full);
            errors++; end
          if (e.cancel_found != out_data.cancel_found) begin
            $error("cancel_found exp %0h got %0h", e.cancel_found,
                   out_data.cancel_found); errors++; end
          if (e.trade_total != out_data.trade_total) begin
            $error("trade_total exp %0h got %0h", e.trade_total,
                   out_data.trade_total); errors++; end
          if (e.volume_total != out_data.volume_total) begin
            $error("volume_total exp %0h got %0h", e.volume_total,
                   out_data.volume_total); errors++; end
          if (e.last != out_data.last) begin
            $error("last exp %0h got %0h", e.last, out_data.last); errors++; end
        end
      end
      stall_phase <= stall_phase + 1;
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else if (stall_phase % 300 < 100) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ((stall_phase % 7) != 0) && ($urandom_range(3, 0) != 0);
      end
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb_limit_order_book_matcher: done, errors");
      $finish;
    end
  end

  task automatic random_order();
    order_t o;
    int pick;
    logic [31:0] px, q;
    pick = $urandom_range(99, 0);
    px = 32'd1000 + $urandom_range(20, 0);
    q = $urandom_range(50, 1);
    if ($urandom_range(19, 0) == 0) q = $urandom;
    if ($urandom_range(29, 0) == 0) px = $urandom;
    if (pick < 55) o = new_order(FUNC_LIMIT, $urandom_range(1, 0), px, q);
    else if (pick < 70) o = new_order(FUNC_MARKET, $urandom_range(1, 0), $urandom, q);
    else if (pick < 92) begin
      o = new_order(FUNC_CANCEL, $urandom_range(1, 0), $urandom, $urandom);
      if (live_count > 0 && $urandom_range(3, 0) != 0)
        o.order_ref = live_ids[$urandom_range(live_count - 1, 0)];
      else if ($urandom_range(1, 0) == 0)
        o.order_ref = {$urandom, $urandom};
    end else if (pick < 96) o = new_order(FUNC_NONE, $urandom_range(1, 0), $urandom, $urandom);
    else o = new_order(FUNC_LIMIT, $urandom_range(1, 0), px, 32'd0);
    queue_order(o);
  endtask

  int drain_wait;
  initial begin
    for (int i = 0; i < Slots; i++) bk_valid[i] = 1'b0;
    arrivals = '0;
    trades = '0;
    volume = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: resting, crossing, time priority, partials, extremes
    queue_order(new_order(FUNC_LIMIT, 1'b1, 32'd100, 32'd10));
    queue_order(new_order(FUNC_LIMIT, 1'b1, 32'd100, 32'd5));
    queue_order(new_order(FUNC_LIMIT, 1'b1, 32'd90, 32'd3));
    queue_order(new_order(FUNC_LIMIT, 1'b0, 32'd100, 32'd12));
    queue_order(new_order(FUNC_LIMIT, 1'b0, 32'd80, 32'd4));
    queue_order(new_order(FUNC_LIMIT, 1'b0, 32'd80, 32'd0));
    queue_order(new_order(FUNC_MARKET, 1'b1, 32'hFFFF_FFFF, 32'd20));
    queue_order(new_order(FUNC_MARKET, 1'b0, 32'd0, 32'd7));
    queue_order(new_order(FUNC_CANCEL, 1'b0, 32'd0, 32'd0));
    queue_order(new_order(FUNC_LIMIT, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    queue_order(new_order(FUNC_LIMIT, 1'b1, 32'd0, 32'hFFFF_FFFF));
    queue_order(new_order(FUNC_NONE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    begin
      order_t c;
      c = new_order(FUNC_CANCEL, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      c.order_ref = 64'd5;
      queue_order(c);
      c = new_order(FUNC_LIMIT, 1'b1, 32'd7, 32'd1);
      c.order_ref = 64'hFFFF_FFFF_FFFF_FFFF;
      queue_order(c);
      c.func = FUNC_CANCEL;
      queue_order(c);
    end
    // fill the table to overflow on one side
    for (int i = 0; i < Slots + 2; i++)
      queue_order(new_order(FUNC_LIMIT, 1'b0, 32'd10 + i, 32'd2));
    // sweep with a market sell taking many fills
    queue_order(new_order(FUNC_MARKET, 1'b1, 32'd0, 32'd1000));

    // long receiver hold-off while the sender keeps going
    wait (accepted >= 8);
    @(posedge clk);
    hold_off <= 400;

    wait (pend_head == pend_tail && !in_valid);
    // sender pause until the matcher drains
    pause_sender = 1;
    wait (exp_head == exp_tail);
    pause_sender = 0;

    for (int i = 0; i < 110; i++) random_order();
    wait (pend_head == pend_tail && !in_valid);
    wait (exp_head == exp_tail);
    drain_wait = 0;
    while (drain_wait < 100) begin
      @(posedge clk);
      drain_wait++;
    end
    if (errors == 0 && exp_head == exp_tail) begin
      $display("tb_limit_order_book_matcher: done, clean");
    end else begin
      $display("tb_limit_order_book_matcher: done, errors");
    end
    $finish;
  end
endmodule

### limit_order_book_matcher.f
design/lobm_pkg.sv
design/lobm_ctrl.sv
design/lobm_datapath.sv
design/limit_order_book_matcher.sv
tb/sv/tb_limit_order_book_matcher.sv
